[src/mel_triangular_filterbank_top_defines.svh]
// Assertion macros for the mel filterbank RTL.
`ifndef MEL_TRIANGULAR_FILTERBANK_TOP_DEFINES_SVH
`define MEL_TRIANGULAR_FILTERBANK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFB_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define MFB_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define MFB_ASSERT_IMPL(label, clk, rst, prop)
`define MFB_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/mfb_pkg.sv]
// Shared types and constants for the mel filterbank.
package mfb_pkg;
   localparam int SPECTRUM_BINS = 512;
   localparam int NUM_FILTERS   = 32;
   localparam int EDGE_DEPTH    = NUM_FILTERS + 2;
   localparam int MAX_OUT       = 32;
   localparam int FILT_COUNT    = (NUM_FILTERS < MAX_OUT) ? NUM_FILTERS : MAX_OUT;
   localparam int BIN_W         = $clog2(SPECTRUM_BINS);
   localparam int EDGE_AW       = $clog2(EDGE_DEPTH);
   localparam int EDGE_W        = 10;
   localparam int ENERGY_W      = 57;
   localparam logic [1:0] OP_LOAD_EDGE = 2'd0;
   localparam logic [1:0] OP_LOAD_SPEC = 2'd1;
   localparam logic [1:0] OP_COMPUTE   = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [8:0]  index;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [4:0]          filter_index;
      logic [ENERGY_W-1:0] energy;
      logic                last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start_div;    // start weight divider for current bin
      logic mac;          // accumulate product
      logic clear_acc;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mac_done;
   } sts_type;
endpackage

[src/mel_triangular_filterbank_top.sv]
// Load transactions are written when accepted; compute emits one result per filter.
// Per filter: edge reads (ST_E0 to ST_E3), then per covered bin a 27-step weight
// divider, multiply and accumulate, then span-end checks and a result output, plus result stalls.
// Throughput is one compute at a time; loads accept every cycle when idle.
// Synchronous active-high reset clears control state; stores are not cleared.
// Top level of the triangular mel filterbank.
module mel_triangular_filterbank_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mfb_pkg::rsp_type rsp_data
);
   import mfb_pkg::*;
   logic edge_wr, spec_wr;
   logic [EDGE_AW-1:0] edge_rd_addr;
   logic [BIN_W-1:0]   spec_rd_addr;
   logic [EDGE_W-1:0]  edge_rd_data;
   logic [10:0] div_num, div_den;
   cmd_type cmd;
   sts_type sts;
   logic [ENERGY_W-1:0] energy;

   mfb_ctrl u_ctrl (.*);
   mfb_dp   u_dp (.*);
endmodule

[src/mfb_ram.sv]
// Generic single-port-write, registered-read RAM.
module mfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[src/mfb_div.sv]
// Restoring divider: (num << 16) / den, saturated to 16 bits, one bit per cycle.
module mfb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [10:0] num,
   input  logic [10:0] den,
   output logic        done,
   output logic [15:0] quo
);
   import mfb_pkg::*;
   logic [11:0] rem_ff, rem_in;
   logic [26:0] q_ff, q_in;
   logic [10:0] den_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [11:0] shifted;
   logic [11:0] diff;

   always_comb begin
      shifted = {rem_ff[10:0], q_ff[26]};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = {num, 16'd0};
         cnt_in  = 5'd27;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff;
            q_in   = {q_ff[25:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[25:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = (q_ff[26:16] != 11'd0) ? 16'hFFFF : q_ff[15:0];
endmodule

[src/mfb_ctrl.sv]
// Controller: load handling, bin walk per filter, result handshake.
`include "mel_triangular_filterbank_top_defines.svh"
module mfb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mfb_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mfb_pkg::rsp_type       rsp_data,
   output logic                   edge_wr,
   output logic                   spec_wr,
   output logic [mfb_pkg::EDGE_AW-1:0] edge_rd_addr,
   output logic [mfb_pkg::BIN_W-1:0]   spec_rd_addr,
   input  logic [mfb_pkg::EDGE_W-1:0]  edge_rd_data,
   output logic [10:0]            div_num,
   output logic [10:0]            div_den,
   output mfb_pkg::cmd_type       cmd,
   input  mfb_pkg::sts_type       sts,
   input  logic [mfb_pkg::ENERGY_W-1:0] energy
);
   import mfb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_E0, ST_E1, ST_E2, ST_E3, ST_BIN, ST_DIV, ST_MAC, ST_OUT
   } state_type;

   state_type state_ff;
   logic [EDGE_AW-1:0] m_ff;
   logic [EDGE_W-1:0]  lo_ff, c_ff, hi_ff;
   logic [EDGE_W:0]    k_ff;
   logic               fall_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               in_range;

   assign req_ready = (state_ff == ST_IDLE);
   wire accept = req_valid & req_ready;
   assign edge_wr = accept && req_data.operation == OP_LOAD_EDGE
                    && req_data.index < 9'(EDGE_DEPTH);
   assign spec_wr = accept && req_data.operation == OP_LOAD_SPEC
                    && {2'b0, req_data.index} < 11'(SPECTRUM_BINS);

   always_comb begin
      edge_rd_addr = m_ff;
      if (state_ff == ST_E1) edge_rd_addr = EDGE_AW'(m_ff + 1);
      if (state_ff == ST_E2) edge_rd_addr = EDGE_AW'(m_ff + 2);
   end
   assign spec_rd_addr = k_ff[BIN_W-1:0];
   assign div_num = fall_ff ? 11'({1'b0, hi_ff} - k_ff) : 11'(k_ff - {1'b0, lo_ff});
   assign div_den = fall_ff ? 11'(hi_ff - c_ff) : 11'(c_ff - lo_ff);

   // bin k is active if inside current span and below spectrum size
   assign in_range = (k_ff < (fall_ff ? {1'b0, hi_ff} : {1'b0, c_ff}))
                     && k_ff < 11'(SPECTRUM_BINS);

   always_comb begin
      cmd = '0;
      cmd.clear_acc = (state_ff == ST_E3);
      cmd.start_div = (state_ff == ST_BIN) && in_range;
      cmd.mac       = (state_ff == ST_DIV) && sts.div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         m_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_data.operation == OP_COMPUTE) begin
                  m_ff     <= '0;
                  state_ff <= ST_E0;
               end
            end
            ST_E0: state_ff <= ST_E1;
            ST_E1: begin
               lo_ff    <= edge_rd_data;
               state_ff <= ST_E2;
            end
            ST_E2: begin
               c_ff     <= edge_rd_data;
               state_ff <= ST_E3;
            end
            ST_E3: begin
               hi_ff    <= edge_rd_data;
               k_ff     <= (c_ff <= lo_ff) ? {1'b0, c_ff} : {1'b0, lo_ff};
               fall_ff  <= (c_ff <= lo_ff);
               state_ff <= ST_BIN;
            end
            ST_BIN: begin
               if (in_range) state_ff <= ST_DIV;
               else if (!fall_ff) begin
                  fall_ff <= 1'b1;
                  k_ff    <= {1'b0, c_ff};
               end else state_ff <= ST_OUT;
            end
            ST_DIV: if (sts.div_done) state_ff <= ST_MAC;
            ST_MAC: if (sts.mac_done) begin
               k_ff     <= k_ff + 11'd1;
               state_ff <= ST_BIN;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.filter_index <= 5'(m_ff);
                  rsp_ff.energy       <= energy;
                  rsp_ff.last         <= (m_ff == EDGE_AW'(FILT_COUNT - 1));
                  if (m_ff == EDGE_AW'(FILT_COUNT - 1)) state_ff <= ST_IDLE;
                  else begin
                     m_ff     <= m_ff + 1'b1;
                     state_ff <= ST_E0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MFB_ASSERT_IMPL(a_busy_no_ready, clock, reset, (state_ff != ST_IDLE) |-> !req_ready)
   `MFB_ASSERT_IMPL(a_mac_after_div, clock, reset, cmd.mac |-> (state_ff == ST_DIV))
endmodule

[src/mfb_dp.sv]
// Datapath: edge and spectrum stores, weight divider, multiply-accumulate.
module mfb_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  mfb_pkg::req_type            req_data,
   input  logic                        edge_wr,
   input  logic                        spec_wr,
   input  logic [mfb_pkg::EDGE_AW-1:0] edge_rd_addr,
   input  logic [mfb_pkg::BIN_W-1:0]   spec_rd_addr,
   output logic [mfb_pkg::EDGE_W-1:0]  edge_rd_data,
   input  logic [10:0]                 div_num,
   input  logic [10:0]                 div_den,
   input  mfb_pkg::cmd_type            cmd,
   output mfb_pkg::sts_type            sts,
   output logic [mfb_pkg::ENERGY_W-1:0] energy
);
   import mfb_pkg::*;
   localparam logic [ENERGY_W-1:0] EMAX = '1;
   logic [31:0] spec_q;
   logic [15:0] quo;
   logic        div_done;
   logic [47:0] prod_ff;
   logic [ENERGY_W-1:0] acc_ff;
   logic [1:0] mstep_ff;
   logic [ENERGY_W:0] sum;

   mfb_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge (
      .clock(clock), .wr_en(edge_wr), .wr_addr(req_data.index[EDGE_AW-1:0]),
      .wr_data(req_data.value[EDGE_W-1:0]), .rd_addr(edge_rd_addr),
      .rd_data(edge_rd_data));
   mfb_ram #(.WIDTH(32), .DEPTH(SPECTRUM_BINS)) u_spec (
      .clock(clock), .wr_en(spec_wr), .wr_addr(req_data.index[BIN_W-1:0]),
      .wr_data(req_data.value), .rd_addr(spec_rd_addr), .rd_data(spec_q));
   mfb_div u_div (
      .clock(clock), .reset(reset), .start(cmd.start_div), .num(div_num),
      .den(div_den), .done(div_done), .quo(quo));

   assign sum = {1'b0, acc_ff} + (ENERGY_W+1)'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) mstep_ff <= '0;
      else if (cmd.mac) mstep_ff <= 2'd1;
      else if (mstep_ff == 2'd1) mstep_ff <= 2'd2;
      else mstep_ff <= '0;
      if (cmd.mac) prod_ff <= 48'(quo) * 48'(spec_q);
      if (cmd.clear_acc) acc_ff <= '0;
      else if (mstep_ff == 2'd1) acc_ff <= sum[ENERGY_W] ? EMAX : sum[ENERGY_W-1:0];
   end

   always_comb begin
      sts.div_done = div_done;
      sts.mac_done = (mstep_ff == 2'd2);
   end
   assign energy = acc_ff;
endmodule
